// ===== hdl/tlic_pkg.sv =====
// package for the thin lens image chain
// operation codes, payload structs, controller state type, command and status groups
// no dependencies
package tlic_pkg;

   localparam int COORD_BITS_DEF = 16;
   localparam int FIELD_W        = 16;

   localparam logic OP_START = 1'b0;
   localparam logic OP_LENS  = 1'b1;

   typedef struct packed {
      logic                      operation;
      logic signed [FIELD_W-1:0] position;
      logic signed [FIELD_W-1:0] magnitude;
      logic                      final_item;
   } req_type;

   typedef struct packed {
      logic signed [FIELD_W-1:0] image_position;
      logic signed [FIELD_W-1:0] image_height;
      logic signed [FIELD_W-1:0] image_distance;
      logic                      image_formed;
      logic                      real_image;
      logic                      lens_applied;
      logic                      final_result;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DIV1_LOAD,
      ST_DIV1,
      ST_CLAMP,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_SUM,
      ST_DIV2_LOAD,
      ST_DIV2,
      ST_FINISH,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic capture;
      logic start;
      logic degen;
      logic mul1;
      logic div_load1;
      logic div_step;
      logic clamp;
      logic mul_lo;
      logic mul_hi;
      logic sum;
      logic div_load2;
      logic finish;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic is_start;
      logic skip;
      logic degen;
      logic slot_free;
   } status_type;

endpackage

// ===== hdl/thin_lens_image_chain.sv =====
// thin lens image chain, top level
// a start, a skipped lens or a lens without image goes from capture through evaluation to
//   the result write; a lens that forms an image also takes the first divider pass, the
//   clamp, the multiplies, the sum, the second divider pass and the finish step; one item
//   is in flight; a waiting result in the result register does not block the next transfer
// reset: synchronous, clears the optical state to zero and empties the result register
module thin_lens_image_chain #(
   parameter int COORD_BITS = tlic_pkg::COORD_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tlic_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tlic_pkg::rsp_type rsp_data
);

   tlic_pkg::cmd_type    cmd;
   tlic_pkg::status_type status;

   tlic_ctrl #(
      .COORD_BITS (COORD_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tlic_dp #(
      .COORD_BITS (COORD_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // one item in flight at a time
   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("transfer accepted while an item is in flight");

   // a result is never written over an unaccepted one
   a_emit_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid || !rsp_stall))
      else $error("result register overwritten");

   a_valid_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.emit))
      else $error("result valid without a result write");

   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("datapath commands overlap");

endmodule

// ===== hdl/tlic_ctrl.sv =====
// controller for the thin lens image chain
// sequences the shared multiplier and radix-2 divider, counts divider steps
// depends on tlic_pkg
module tlic_ctrl #(
   parameter int COORD_BITS = tlic_pkg::COORD_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  tlic_pkg::status_type status,
   output tlic_pkg::cmd_type    cmd
);

   localparam int CW = $clog2(2 * COORD_BITS);
   localparam logic [CW-1:0] N1 = CW'(2 * COORD_BITS - 1);
   localparam logic [CW-1:0] N2 = CW'(COORD_BITS - 1);

   tlic_pkg::state_type state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic                plain;

   assign plain = status.is_start || status.skip || status.degen;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tlic_pkg::ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tlic_pkg::ST_IDLE: begin
            if (req_valid) state_in = tlic_pkg::ST_EVAL;
         end
         tlic_pkg::ST_EVAL: begin
            state_in = plain ? tlic_pkg::ST_RESULT : tlic_pkg::ST_DIV1_LOAD;
         end
         tlic_pkg::ST_DIV1_LOAD: state_in = tlic_pkg::ST_DIV1;
         tlic_pkg::ST_DIV1: begin
            if (count_ff == '0) state_in = tlic_pkg::ST_CLAMP;
         end
         tlic_pkg::ST_CLAMP:     state_in = tlic_pkg::ST_MUL_LO;
         tlic_pkg::ST_MUL_LO:    state_in = tlic_pkg::ST_MUL_HI;
         tlic_pkg::ST_MUL_HI:    state_in = tlic_pkg::ST_SUM;
         tlic_pkg::ST_SUM:       state_in = tlic_pkg::ST_DIV2_LOAD;
         tlic_pkg::ST_DIV2_LOAD: state_in = tlic_pkg::ST_DIV2;
         tlic_pkg::ST_DIV2: begin
            if (count_ff == '0) state_in = tlic_pkg::ST_FINISH;
         end
         tlic_pkg::ST_FINISH:    state_in = tlic_pkg::ST_RESULT;
         tlic_pkg::ST_RESULT: begin
            if (status.slot_free) state_in = tlic_pkg::ST_IDLE;
         end
         default:                state_in = tlic_pkg::ST_IDLE;
      endcase
   end

   // step counter
   always_comb begin
      count_in = count_ff;
      unique case (state_ff)
         tlic_pkg::ST_DIV1_LOAD: count_in = N1;
         tlic_pkg::ST_DIV2_LOAD: count_in = N2;
         tlic_pkg::ST_DIV1,
         tlic_pkg::ST_DIV2:      count_in = count_ff - CW'(1);
         default:                count_in = count_ff;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         tlic_pkg::ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         tlic_pkg::ST_EVAL: begin
            cmd.start = status.is_start;
            cmd.degen = !status.is_start && !status.skip && status.degen;
            cmd.mul1  = !plain;
         end
         tlic_pkg::ST_DIV1_LOAD: cmd.div_load1 = 1'b1;
         tlic_pkg::ST_DIV1:      cmd.div_step  = 1'b1;
         tlic_pkg::ST_CLAMP:     cmd.clamp     = 1'b1;
         tlic_pkg::ST_MUL_LO:    cmd.mul_lo    = 1'b1;
         tlic_pkg::ST_MUL_HI:    cmd.mul_hi    = 1'b1;
         tlic_pkg::ST_SUM:       cmd.sum       = 1'b1;
         tlic_pkg::ST_DIV2_LOAD: cmd.div_load2 = 1'b1;
         tlic_pkg::ST_DIV2:      cmd.div_step  = 1'b1;
         tlic_pkg::ST_FINISH:    cmd.finish    = 1'b1;
         tlic_pkg::ST_RESULT:    cmd.emit      = status.slot_free;
         default:                cmd           = '0;
      endcase
   end

endmodule

// ===== hdl/tlic_dp.sv =====
// datapath for the thin lens image chain
// optical state, shared multiplier, radix-2 divider, saturation, result register
// depends on tlic_pkg
module tlic_dp #(
   parameter int COORD_BITS = tlic_pkg::COORD_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tlic_pkg::req_type    req_data,
   input  tlic_pkg::cmd_type    cmd,
   output tlic_pkg::status_type status,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output tlic_pkg::rsp_type    rsp_data
);

   localparam int C     = COORD_BITS;
   localparam int FW    = tlic_pkg::FIELD_W;
   localparam int IW    = (C > FW) ? C : FW;
   localparam int DIM_W = (2 * C < 62 - C) ? 2 * C : 62 - C;
   localparam int SW    = ((DIM_W > C) ? DIM_W : C) + 2;
   localparam longint CMAX = (longint'(1) <<< (C - 1)) - longint'(1);
   localparam longint CMIN = -CMAX - longint'(1);
   localparam logic [63:0] LIM64 = (64'd1 << (62 - C)) - 64'd1;
   localparam logic signed [IW-1:0] IN_MAX = IW'(CMAX);
   localparam logic signed [IW-1:0] IN_MIN = IW'(CMIN);
   localparam logic signed [SW-1:0] S_MAX  = SW'(CMAX);
   localparam logic signed [SW-1:0] S_MIN  = SW'(CMIN);
   localparam logic [C-1:0] C_MAX = C'(CMAX);
   localparam logic [C-1:0] C_MIN = C'(CMIN);

   // optical state
   logic signed [C-1:0] cur_pos_ff, cur_h_ff, cur_d_ff, saved_ff;
   logic                formed_ff;

   // captured item
   logic                op_ff, fin_ff, applied_ff;
   logic signed [C-1:0] pos_ff, mag_ff;

   // working registers
   logic [C-1:0]     do_mag_ff;
   logic [C:0]       den_mag_ff;
   logic             do_neg_ff, di_neg_ff, ovf_ff;
   logic [2*C-1:0]   prod_ff;
   logic [3*C-1:0]   acc_ff;
   logic [DIM_W-1:0] dim_ff;
   logic [2*C-1:0]   num_ff, num_in;
   logic [C:0]       rem_ff, rem_in, dvs_ff;

   tlic_pkg::rsp_type rsp_ff;
   logic              rsp_valid_ff;

   // input saturation
   logic signed [IW-1:0] pos_ext, mag_ext_in;
   logic signed [C-1:0]  pos_sat, mag_sat;

   assign pos_ext    = IW'(req_data.position);
   assign mag_ext_in = IW'(req_data.magnitude);
   assign pos_sat = (pos_ext > IN_MAX) ? C_MAX :
                    (pos_ext < IN_MIN) ? C_MIN : pos_ext[C-1:0];
   assign mag_sat = (mag_ext_in > IN_MAX) ? C_MAX :
                    (mag_ext_in < IN_MIN) ? C_MIN : mag_ext_in[C-1:0];

   // object distance, denominator and magnitudes
   logic signed [C:0]   d_o, d_o_neg, mag_ext, mag_neg, h_ext, h_negv;
   logic signed [C+1:0] den, den_neg;
   logic [C-1:0]        do_mag, f_mag, h_mag;
   logic [C:0]          den_mag;

   assign d_o     = (C+1)'(pos_ff) - (C+1)'(cur_pos_ff);
   assign d_o_neg = -d_o;
   assign den     = (C+2)'(d_o) - (C+2)'(mag_ff);
   assign den_neg = -den;
   assign mag_ext = (C+1)'(mag_ff);
   assign mag_neg = -mag_ext;
   assign h_ext   = (C+1)'(cur_h_ff);
   assign h_negv  = -h_ext;
   assign do_mag  = d_o[C] ? d_o_neg[C-1:0] : d_o[C-1:0];
   assign f_mag   = mag_ext[C] ? mag_neg[C-1:0] : mag_ext[C-1:0];
   assign h_mag   = h_ext[C] ? h_negv[C-1:0] : h_ext[C-1:0];
   assign den_mag = den[C+1] ? den_neg[C:0] : den[C:0];

   assign status.is_start  = (op_ff == tlic_pkg::OP_START);
   assign status.skip      = (op_ff == tlic_pkg::OP_LENS) && (saved_ff > pos_ff);
   assign status.degen     = (d_o == '0) || (den == '0);
   assign status.slot_free = !rsp_valid_ff || !rsp_stall;

   // shared multiplier
   logic [2*C-1:0] dpad, mul_p;
   logic [C-1:0]   mul_a, mul_b;

   assign dpad  = (2*C)'(dim_ff);
   assign mul_a = cmd.mul1 ? do_mag : (cmd.mul_lo ? dpad[C-1:0] : dpad[2*C-1:C]);
   assign mul_b = cmd.mul1 ? f_mag : h_mag;
   assign mul_p = mul_a * mul_b;

   // restoring divider step
   logic [C+1:0] trial, diff;
   logic         ge;

   assign trial = {rem_ff, num_ff[2*C-1]};
   assign ge    = trial >= {1'b0, dvs_ff};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      num_in = num_ff;
      rem_in = rem_ff;
      if (cmd.div_load1) begin
         num_in = prod_ff;
         rem_in = '0;
      end else if (cmd.div_load2) begin
         num_in = {acc_ff[C-1:0], {C{1'b0}}};
         rem_in = acc_ff[2*C:C];
      end else if (cmd.div_step) begin
         num_in = {num_ff[2*C-2:0], ge};
         rem_in = ge ? diff[C:0] : trial[C:0];
      end
   end

   // clamp of the image distance
   logic over;
   assign over = 64'(num_ff) > LIM64;

   // final values
   logic signed [SW-1:0] di_u, di_s, pos_sum;
   logic signed [C-1:0]  pos_new, d_new, h_new;
   logic [C-1:0]         q2, q2_neg;
   logic                 big, hi_neg;

   assign di_u    = SW'(dim_ff);
   assign di_s    = di_neg_ff ? -di_u : di_u;
   assign pos_sum = SW'(pos_ff) + di_s;
   assign pos_new = (pos_sum > S_MAX) ? C_MAX :
                    (pos_sum < S_MIN) ? C_MIN : pos_sum[C-1:0];
   assign d_new   = (di_s > S_MAX) ? C_MAX :
                    (di_s < S_MIN) ? C_MIN : di_s[C-1:0];
   assign q2      = num_ff[C-1:0];
   assign q2_neg  = -q2;
   assign big     = ovf_ff || q2[C-1];
   assign hi_neg  = ~(di_neg_ff ^ cur_h_ff[C-1] ^ do_neg_ff);
   assign h_new   = hi_neg ? (big ? C_MIN : q2_neg) : (big ? C_MAX : q2);

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_pos_ff <= '0;
         cur_h_ff   <= '0;
         cur_d_ff   <= '0;
         formed_ff  <= 1'b0;
         saved_ff   <= '0;
      end else if (cmd.start) begin
         cur_pos_ff <= pos_ff;
         cur_h_ff   <= mag_ff;
         cur_d_ff   <= '0;
         formed_ff  <= 1'b0;
         saved_ff   <= pos_ff;
      end else if (cmd.degen) begin
         formed_ff  <= 1'b0;
         saved_ff   <= cur_pos_ff;
      end else if (cmd.mul1) begin
         saved_ff   <= cur_pos_ff;
      end else if (cmd.finish) begin
         cur_pos_ff <= pos_new;
         cur_h_ff   <= h_new;
         cur_d_ff   <= d_new;
         formed_ff  <= 1'b1;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff      <= req_data.operation;
         pos_ff     <= pos_sat;
         mag_ff     <= mag_sat;
         fin_ff     <= req_data.final_item;
         applied_ff <= 1'b0;
      end
      if (cmd.degen || cmd.mul1) begin
         applied_ff <= 1'b1;
      end
      if (cmd.mul1) begin
         do_mag_ff  <= do_mag;
         den_mag_ff <= den_mag;
         do_neg_ff  <= d_o[C];
         di_neg_ff  <= d_o[C] ^ mag_ff[C-1] ^ den[C+1];
      end
      if (cmd.mul1 || cmd.mul_lo || cmd.mul_hi) begin
         prod_ff <= mul_p;
      end
      if (cmd.mul_hi) begin
         acc_ff <= (3*C)'(prod_ff);
      end else if (cmd.sum) begin
         acc_ff <= acc_ff + {prod_ff, {C{1'b0}}};
      end
      if (cmd.clamp) begin
         dim_ff <= over ? DIM_W'(LIM64) : DIM_W'(num_ff);
      end
      if (cmd.div_load1) begin
         dvs_ff <= den_mag_ff;
      end else if (cmd.div_load2) begin
         dvs_ff <= {1'b0, do_mag_ff};
         ovf_ff <= acc_ff[3*C-1:C] >= (2*C)'(do_mag_ff);
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
   end

   // result register
   logic signed [IW-1:0] pos_o, h_o, d_o_out;

   assign pos_o   = IW'(cur_pos_ff);
   assign h_o     = IW'(cur_h_ff);
   assign d_o_out = IW'(cur_d_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_ff.image_position <= pos_o[FW-1:0];
         rsp_ff.image_height   <= h_o[FW-1:0];
         rsp_ff.image_distance <= d_o_out[FW-1:0];
         rsp_ff.image_formed   <= formed_ff;
         rsp_ff.real_image     <= formed_ff && !cur_d_ff[C-1] && (cur_d_ff != '0);
         rsp_ff.lens_applied   <= applied_ff;
         rsp_ff.final_result   <= fin_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
